@@ rtl/core/bcec_pkg.sv @@
// Shared types and constants for the block cache enhanced clock controller.
// Depends on nothing; used by every file in rtl/core.
package bcec_pkg;

  localparam int unsigned ENTRIES_DEF = 8;
  localparam logic [31:0] INVALID_TAG = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MARK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP1,
    ST_SWEEP2,
    ST_VICT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sector;
    logic [7:0]  entry;
  } req_t;

  typedef struct packed {
    logic [7:0]  index;
    logic        hit;
    logic        writeback;
    logic [31:0] writeback_sector;
    logic        fill;
    logic [31:0] fill_sector;
    logic        zero_fill;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the request
    logic cnt_clr;   // step counter to zero
    logic cnt_inc;   // step counter + 1
    logic rd_en;     // tag memory read
    logic rd_hand;   // read at the hand, else at next counter value
    logic set_hit;   // lookup matched at counter
    logic ref_clr;   // clear reference bit at the hand
    logic hand_adv;  // advance the hand
    logic commit;    // load result register and update state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;     // tag read back equals the lookup address
    logic cnt_last;  // counter at last entry
    logic cand1;     // entry at hand unreferenced and clean
    logic cand2;     // entry at hand clean
  } sts_t;

endpackage

@@ rtl/core/bcec_dpath.sv @@
// Datapath: tag memory, reference/dirty/valid bits, clock hand, result register.
// Depends on bcec_pkg; driven by bcec_ctrl through cmd_t / sts_t.
module bcec_dpath #(
  parameter int unsigned ENTRIES = bcec_pkg::ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_data_i,
  input  bcec_pkg::req_t   in_data_i,
  input  bcec_pkg::cmd_t   cmd_i,
  output bcec_pkg::sts_t   sts_o,
  output bcec_pkg::rsp_t   out_data_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  logic [31:0]        base_q;
  logic [1:0]         op_q;
  logic [31:0]        addr_q;
  logic [7:0]         entry_q;
  logic               hit_q;
  logic [IdxW-1:0]    cnt_q, cnt_d;
  logic [IdxW-1:0]    hand_q, hand_nxt;
  logic [ENTRIES-1:0] ref_q, dirty_q, vld_q;
  logic [31:0]        tag_mem [ENTRIES];
  logic [31:0]        rd_tag_q;
  logic               rd_vld_q;
  logic [IdxW-1:0]    rd_addr;
  logic [31:0]        eff_tag;
  logic               entry_ok;
  logic               tag_we;
  bcec_pkg::rsp_t     rsp_d, rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= '0;
      hit_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load) begin
        op_q  <= in_data_i.op;
        hit_q <= 1'b0;
      end else if (cmd_i.set_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= (in_data_i.op == bcec_pkg::OP_READ) ? in_data_i.sector + base_q
                                                     : in_data_i.sector;
      entry_q <= in_data_i.entry;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign hand_nxt = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
  assign rd_addr  = cmd_i.rd_hand ? hand_q : cnt_d;
  assign eff_tag  = rd_vld_q ? rd_tag_q : bcec_pkg::INVALID_TAG;
  assign entry_ok = ({1'b0, entry_q} < 9'(ENTRIES));
  assign tag_we   = cmd_i.commit && !hit_q &&
                    ((op_q == bcec_pkg::OP_READ) || (op_q == bcec_pkg::OP_CLEAR));

  // tag memory, registered read
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[hand_q] <= addr_q;
    end
    if (cmd_i.rd_en) begin
      rd_tag_q <= tag_mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  always_comb begin
    sts_o.match    = (eff_tag == addr_q) && (addr_q != bcec_pkg::INVALID_TAG);
    sts_o.cnt_last = (cnt_q == LastIdx);
    sts_o.cand1    = !ref_q[hand_q] && !dirty_q[hand_q];
    sts_o.cand2    = !dirty_q[hand_q];
  end

  // replacement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= '0;
      dirty_q <= '0;
      vld_q   <= '0;
      hand_q  <= '0;
    end else if (cmd_i.commit) begin
      case (op_q)
        bcec_pkg::OP_READ: begin
          if (hit_q) begin
            ref_q[cnt_q] <= 1'b1;
          end else begin
            vld_q[hand_q]   <= 1'b1;
            ref_q[hand_q]   <= 1'b1;
            dirty_q[hand_q] <= 1'b0;
            hand_q          <= hand_nxt;
          end
        end
        bcec_pkg::OP_CLEAR: begin
          vld_q[hand_q]   <= 1'b1;
          ref_q[hand_q]   <= 1'b0;
          dirty_q[hand_q] <= 1'b0;
          hand_q          <= hand_nxt;
        end
        bcec_pkg::OP_MARK: begin
          if (entry_ok) begin
            dirty_q[entry_q[IdxW-1:0]] <= 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      if (cmd_i.ref_clr) begin
        ref_q[hand_q] <= 1'b0;
      end
      if (cmd_i.hand_adv) begin
        hand_q <= hand_nxt;
      end
    end
  end

  // result formatting
  always_comb begin
    rsp_d = '0;
    case (op_q)
      bcec_pkg::OP_READ: begin
        if (hit_q) begin
          rsp_d.index = 8'(cnt_q);
          rsp_d.hit   = 1'b1;
        end else begin
          rsp_d.index            = 8'(hand_q);
          rsp_d.writeback        = (eff_tag != bcec_pkg::INVALID_TAG) && dirty_q[hand_q];
          rsp_d.writeback_sector = rsp_d.writeback ? eff_tag : '0;
          rsp_d.fill             = 1'b1;
          rsp_d.fill_sector      = addr_q;
        end
      end
      bcec_pkg::OP_CLEAR: begin
        rsp_d.index            = 8'(hand_q);
        rsp_d.writeback        = (eff_tag != bcec_pkg::INVALID_TAG) && dirty_q[hand_q];
        rsp_d.writeback_sector = rsp_d.writeback ? eff_tag : '0;
        rsp_d.zero_fill        = 1'b1;
      end
      bcec_pkg::OP_MARK: begin
        rsp_d.index = entry_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_data_o = rsp_q;

endmodule

@@ rtl/core/bcec_ctrl.sv @@
// Controller: sequences lookup, two-sweep victim search and result hand-off.
// Depends on bcec_pkg; commands bcec_dpath through cmd_t / sts_t.
module bcec_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  bcec_pkg::sts_t  sts_i,
  output bcec_pkg::cmd_t  cmd_o
);

  bcec_pkg::state_e state_q, state_d;
  logic             out_valid_q;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcec_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bcec_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          case (in_op_i)
            bcec_pkg::OP_READ: begin
              cmd_o.rd_en = 1'b1;   // tag of entry 0
              state_d     = bcec_pkg::ST_LOOKUP;
            end
            bcec_pkg::OP_CLEAR: state_d = bcec_pkg::ST_SWEEP1;
            default:            state_d = bcec_pkg::ST_RESP;
          endcase
        end
      end
      bcec_pkg::ST_LOOKUP: begin
        if (sts_i.match) begin
          cmd_o.set_hit = 1'b1;
          state_d       = bcec_pkg::ST_RESP;
        end else if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = bcec_pkg::ST_SWEEP1;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          cmd_o.rd_en   = 1'b1;
        end
      end
      bcec_pkg::ST_SWEEP1: begin
        if (sts_i.cand1) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_hand = 1'b1;
          state_d       = bcec_pkg::ST_RESP;
        end else begin
          cmd_o.ref_clr  = 1'b1;
          cmd_o.hand_adv = 1'b1;
          if (sts_i.cnt_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = bcec_pkg::ST_SWEEP2;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      bcec_pkg::ST_SWEEP2: begin
        if (sts_i.cand2) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_hand = 1'b1;
          state_d       = bcec_pkg::ST_RESP;
        end else begin
          cmd_o.hand_adv = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = bcec_pkg::ST_VICT;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      bcec_pkg::ST_VICT: begin
        // both sweeps failed: victim is the entry at the hand
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_hand = 1'b1;
        state_d       = bcec_pkg::ST_RESP;
      end
      bcec_pkg::ST_RESP: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = bcec_pkg::ST_IDLE;
        end
      end
      default: state_d = bcec_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/block_cache_enhanced_clock.sv @@
// Top level of the block cache tag and enhanced-clock replacement controller.
// Depends on bcec_pkg, bcec_ctrl and bcec_dpath.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid_i  in_ready_o  in_data_i     | request in
//   out     | out_valid_o out_ready_i out_data_o    | result out
//   cfg     | cfg_valid_i cfg_ready_o cfg_data_i    | base_offset write
//
// One request at a time. Mark-dirty and unused ops go straight to the result; a read
// compares one tag per cycle over the tag memory's single read port, and a miss or
// clear steps the clock hand one entry per cycle through both sweeps.
// The result sits in an output register, so the next request is taken while it
// waits; a stalled output only holds the following result in its final state.
// Reset (rst_ni low, asynchronous) invalidates all entries at once through
// per-entry valid bits, clears reference/dirty bits, the hand and base_offset.
// cfg_ready_o is always high; each cfg transfer updates base_offset.
module block_cache_enhanced_clock #(
  parameter int unsigned ENTRIES = bcec_pkg::ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bcec_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bcec_pkg::rsp_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [31:0]     cfg_data_i
);

  bcec_pkg::cmd_t cmd;
  bcec_pkg::sts_t sts;
  logic           cfg_we;

  // register writes never stall
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  bcec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_op_i     (in_data_i.op),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcec_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // never overwrite a result that has not been taken
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten while pending");

  // a commit always presents a result next cycle
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  // accept, hand step and commit belong to different phases
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.commit, cmd.hand_adv}))
    else $error("overlapping controller phases");

  // a hit never asks for device traffic
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |-> (!out_data_o.fill && !out_data_o.writeback
                                         && !out_data_o.zero_fill))
    else $error("hit result carries fill or writeback");
`endif

endmodule

@@ test/tb_block_cache_enhanced_clock.sv @@
`timescale 1ns / 100ps
// Testbench for block_cache_enhanced_clock: tag lookup, enhanced clock victim
// choice, writeback/fill/zero-fill requests and mark-dirty. Depends on bcec_pkg
// and the RTL under rtl/core; self-contained otherwise.
module tb_block_cache_enhanced_clock;
  import bcec_pkg::*;

  localparam int unsigned ENTRIES      = ENTRIES_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;  // op code with no meaning
  localparam int unsigned DRAIN_CYCLES = 32;    // settling time in wait_idle
  localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int unsigned MAX_REPORTS  = 100;
  localparam longint      TIMEOUT_NS   = 4_000_000;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  block_cache_enhanced_clock #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache state, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [31:0] tag_m   [ENTRIES];
  bit          ref_m   [ENTRIES];
  bit          dirty_m [ENTRIES];
  int unsigned hand_m;
  logic [31:0] base_m;

  rsp_t        pending_rsp[$];   // predicted results, oldest first
  int unsigned mismatches = 0;
  int unsigned reports    = 0;

  // idle/stall odds in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic [31:0] pool_base     = '0;  // sectors of the current working set

  // run statistics, counted from checked results
  int unsigned n_checked = 0;
  int unsigned n_hits    = 0;
  int unsigned n_fills   = 0;
  int unsigned n_wbacks  = 0;
  int unsigned n_zfills  = 0;

  // receiver hold-off control
  event        hold_start;
  logic        hold_on = 1'b0;

  function automatic int unsigned hand_step(input int unsigned h);
    return (h + 1 >= ENTRIES) ? 0 : h + 1;
  endfunction

  // Two sweeps from the hand: first wants unreferenced+clean and strips
  // reference bits on the way; second wants any clean entry; else the hand.
  function automatic int unsigned choose_victim();
    int unsigned n;
    int unsigned v;
    bit          found;
    found = 1'b0;
    for (n = 0; n < ENTRIES && !found; n++) begin
      if (!ref_m[hand_m]) begin
        if (!dirty_m[hand_m]) found = 1'b1;
      end else begin
        ref_m[hand_m] = 1'b0;
      end
      if (!found) hand_m = hand_step(hand_m);
    end
    for (n = 0; n < ENTRIES && !found; n++) begin
      if (!dirty_m[hand_m]) found = 1'b1;
      else hand_m = hand_step(hand_m);
    end
    v      = hand_m;
    hand_m = hand_step(hand_m);
    return v;
  endfunction

  // Victim replacement common to read misses and clears: writeback if the old
  // entry holds a valid tag and is dirty.
  function automatic void evict_into(input int unsigned v, inout rsp_t p);
    if (tag_m[v] != INVALID_TAG && dirty_m[v]) begin
      p.writeback        = 1'b1;
      p.writeback_sector = tag_m[v];
    end
    dirty_m[v] = 1'b0;
    p.index    = v[7:0];
  endfunction

  function automatic rsp_t cache_predict(input req_t r);
    rsp_t        p;
    logic [31:0] addr;
    int unsigned k;
    int unsigned v;
    bit          hit_found;
    p         = '0;
    hit_found = 1'b0;
    case (r.op)
      OP_READ: begin
        addr = r.sector + base_m;
        // all-ones tag means invalid, so that address never hits
        if (addr != INVALID_TAG) begin
          for (k = 0; k < ENTRIES; k++) begin
            if (!hit_found && tag_m[k] == addr) begin
              hit_found = 1'b1;
              ref_m[k]  = 1'b1;
              p.index   = k[7:0];
              p.hit     = 1'b1;
            end
          end
        end
        if (!hit_found) begin
          v = choose_victim();
          evict_into(v, p);
          p.fill        = 1'b1;
          p.fill_sector = addr;
          tag_m[v]      = addr;
          ref_m[v]      = 1'b1;
        end
      end
      OP_CLEAR: begin
        v = choose_victim();
        evict_into(v, p);
        p.zero_fill = 1'b1;
        tag_m[v]    = r.sector;
        ref_m[v]    = 1'b0;
      end
      OP_MARK: begin
        // out-of-range entry: nothing changes, index still echoed
        if (r.entry < ENTRIES) dirty_m[r.entry] = 1'b1;
        p.index = r.entry;
      end
      default: ;  // unused op: all-zero result
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-off, compare against oldest prediction
  // ---------------------------------------------------------------------------
  always begin : hold_ctrl
    @(hold_start);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      reports++;
      if (reports <= MAX_REPORTS)
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $error("result transfer with nothing expected: 0x%0h", out_data_o);
      end else begin
        want = pending_rsp.pop_front();
        n_checked++;
        if (want.hit) n_hits++;
        if (want.fill) n_fills++;
        if (want.writeback) n_wbacks++;
        if (want.zero_fill) n_zfills++;
        check_field("index", 32'(want.index), 32'(out_data_o.index));
        check_field("hit", 32'(want.hit), 32'(out_data_o.hit));
        check_field("writeback", 32'(want.writeback), 32'(out_data_o.writeback));
        check_field("writeback_sector", want.writeback_sector,
                    out_data_o.writeback_sector);
        check_field("fill", 32'(want.fill), 32'(out_data_o.fill));
        check_field("fill_sector", want.fill_sector, out_data_o.fill_sector);
        check_field("zero_fill", 32'(want.zero_fill), 32'(out_data_o.zero_fill));
      end
    end
    out_ready_i <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Request side. All tasks are entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one request; valid stays up after the transfer so back-to-back
  // requests never drop it within a step.
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp.push_back(cache_predict(r));
  endtask

  function automatic req_t mk_req(input logic [1:0] op, input logic [31:0] sector,
                                  input logic [7:0] entry);
    req_t r;
    r.op     = op;
    r.sector = sector;
    r.entry  = entry;
    return r;
  endfunction

  // Mostly a small working set so hits, sweeps and writebacks all happen;
  // some fully random sectors/entries and the all-ones address after offset.
  function automatic req_t rand_req();
    req_t        r;
    int unsigned roll;
    logic [31:0] s;
    roll = $urandom_range(99);
    s    = pool_base + $urandom_range(11);
    if (roll < 5) s = $urandom;
    else if (roll < 8) s = INVALID_TAG - base_m;
    r.sector = s;
    r.entry  = 8'($urandom_range(ENTRIES - 1));
    if ($urandom_range(9) == 0) r.entry = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 50) begin
      r.op = OP_READ;
    end else if (roll < 65) begin
      r.op = OP_CLEAR;
      // half the clears land on an address a read can later hit
      if ($urandom_range(1)) r.sector = s + base_m;
    end else if (roll < 93) begin
      r.op = OP_MARK;
    end else begin
      r.op     = OP_UNUSED;
      r.sector = $urandom;
      r.entry  = 8'($urandom_range(255));
    end
    return r;
  endfunction

  // Drop valid and wait until every result is back and the block has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base_offset(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    base_m = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every op and the corner cases, at reset base_offset.
  task automatic test_directed();
    int unsigned k;
    send_idle_pct = 0;
    stall_pct     = 0;
    send_req(mk_req(OP_READ, 32'h0000_0000, 8'h00));   // cold miss
    send_req(mk_req(OP_READ, 32'h0000_0000, 8'hff));   // hit
    send_req(mk_req(OP_READ, INVALID_TAG, 8'h00));     // all-ones address misses
    send_req(mk_req(OP_READ, INVALID_TAG, 8'h00));     // ... and again
    send_req(mk_req(OP_CLEAR, INVALID_TAG, 8'hff));
    send_req(mk_req(OP_CLEAR, 32'h0000_0000, 8'h00));  // duplicate tag
    send_req(mk_req(OP_UNUSED, INVALID_TAG, 8'hff));
    send_req(mk_req(OP_MARK, 32'hffff_ffff, 8'hff));   // entry out of range
    send_req(mk_req(OP_MARK, 32'h0, ENTRIES[7:0]));    // first index out of range
    for (k = 1; k <= 6; k++) send_req(mk_req(OP_READ, k, 8'h00));
    // everything dirty: both sweeps fail, the hand is taken
    for (k = 0; k < ENTRIES; k++) send_req(mk_req(OP_MARK, 32'h0, k[7:0]));
    send_req(mk_req(OP_READ, 32'h0000_0100, 8'h00));
    send_req(mk_req(OP_READ, 32'h0000_0100, 8'h00));
  endtask

  task automatic test_random_phase(input int unsigned n_items, input int unsigned idle,
                                   input int unsigned stall, input logic [31:0] base);
    int unsigned k;
    wait_idle();
    write_base_offset(base);
    send_idle_pct = idle;
    stall_pct     = stall;
    pool_base     = $urandom;
    for (k = 0; k < n_items; k++) send_req(rand_req());
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // output register fills, the next result waits in ST_RESP and in_ready_o drops.
  task automatic test_backpressure();
    int unsigned k;
    wait_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    -> hold_start;
    for (k = 0; k < 24; k++) send_req(rand_req());
  endtask

  initial begin
    for (int unsigned k = 0; k < ENTRIES; k++) begin
      tag_m[k]   = INVALID_TAG;
      ref_m[k]   = 1'b0;
      dirty_m[k] = 1'b0;
    end
    hand_m = 0;
    base_m = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(250, 0, 0, 32'h0000_0000);
    test_random_phase(230, 73, 0, 32'hffff_ffff);
    test_random_phase(230, 0, 73, $urandom);
    test_random_phase(230, 33, 33, 32'h0000_0001);
    test_backpressure();
    wait_idle();

    $display("Checked %0d results: %0d read hits, %0d fills, %0d writebacks, %0d zero fills.",
             n_checked, n_hits, n_fills, n_wbacks, n_zfills);
    $display("Phases: free flow, sender gaps, receiver stalls, both, long hold-off.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", pending_rsp.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
